// File: design/kwsc_pkg.sv
// kwsc_pkg: shared types and constants for the keyword substitution cipher core
// no dependencies
`timescale 1ns / 1ps

package kwsc_pkg;

   localparam int unsigned LETTER_COUNT = 26;
   localparam int unsigned LETTER_W     = 5;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned KIND_W       = 2;

   localparam logic [BYTE_W-1:0] BASE_UPPER = 8'h41;
   localparam logic [BYTE_W-1:0] BASE_LOWER = 8'h61;

   typedef logic [KIND_W-1:0]       kind_type;
   typedef logic [BYTE_W-1:0]       byte_type;
   typedef logic [LETTER_W-1:0]     letter_type;
   typedef logic [LETTER_COUNT-1:0] mask_type;

   localparam kind_type KIND_CLEAR  = 2'd0;
   localparam kind_type KIND_KEY    = 2'd1;
   localparam kind_type KIND_FINISH = 2'd2;
   localparam kind_type KIND_PLAIN  = 2'd3;

   typedef struct packed {
      logic       valid;
      letter_type idx;
   } letter_hit_type;

   // alphabet position of an ascii letter of either case
   function automatic letter_hit_type letter_index(input byte_type b);
      letter_hit_type res;
      byte_type       diff;
      res = '0;
      diff = '0;
      if (b >= BASE_UPPER && b < BASE_UPPER + BYTE_W'(LETTER_COUNT)) begin
         diff = b - BASE_UPPER;
         res.valid = 1'b1;
      end else if (b >= BASE_LOWER && b < BASE_LOWER + BYTE_W'(LETTER_COUNT)) begin
         diff = b - BASE_LOWER;
         res.valid = 1'b1;
      end
      res.idx = diff[LETTER_W-1:0];
      return res;
   endfunction

endpackage

// File: design/keyword_substitution_cipher_core.sv
// keyword_substitution_cipher_core: builds a substitution table from keyword
// letters and encrypts bytes with it; depends on kwsc_pkg
`timescale 1ns / 1ps
//
// channel  direction  tdata            tuser
// req      in         [7:0] in_byte    [1:0] kind
// rsp      out        [7:0] out_byte   -
//
// clear, keyword and plaintext transactions leave the core idle; a plaintext
// byte gives one result in the output register the cycle after acceptance
// a finish transaction walks the 26 letters through the single append unit,
// one letter a cycle, so req_tready is low until the walk is done
// reset restores the identity table, empty used mask and zero fill count
// a waiting result holds req_tready low until rsp_tready takes it

module keyword_substitution_cipher_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,  // [7:0] in_byte
   input  kwsc_pkg::kind_type      req_tuser,  // [1:0] kind
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata   // [7:0] out_byte
);

   import kwsc_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_FILL = 1'b1;

   logic           state_ff, state_in;
   letter_type     walk_ff, walk_in;
   letter_type     table_ff [LETTER_COUNT];
   mask_type       used_ff, used_in;
   letter_type     fill_ff, fill_in;
   logic           rsp_valid_ff, rsp_valid_in;
   byte_type       rsp_data_ff, rsp_data_in;

   logic           req_fire;
   letter_hit_type hit;
   logic           ap_en;
   letter_type     ap_idx;
   logic           ap_new;
   logic           ap_write;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign hit        = letter_index(req_tdata);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // shared append unit, driven by keyword bytes or by the finish walk
   always_comb begin
      ap_en  = 1'b0;
      ap_idx = hit.idx;
      if (state_ff == ST_FILL) begin
         ap_en  = 1'b1;
         ap_idx = walk_ff;
      end else if (req_fire && req_tuser == KIND_KEY) begin
         ap_en  = hit.valid;
      end
   end

   assign ap_new   = ap_en && !used_ff[ap_idx];
   assign ap_write = ap_new && (fill_ff < LETTER_W'(LETTER_COUNT));

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      used_in      = used_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (ap_new) begin
         used_in = used_ff | (LETTER_COUNT'(1) << ap_idx);
      end
      if (ap_write) begin
         fill_in = fill_ff + LETTER_W'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  KIND_CLEAR: begin
                     used_in = '0;
                     fill_in = '0;
                  end
                  KIND_FINISH: begin
                     state_in = ST_FILL;
                     walk_in  = '0;
                  end
                  KIND_PLAIN: begin
                     rsp_valid_in = 1'b1;
                     if (hit.valid) begin
                        rsp_data_in = BASE_UPPER + BYTE_W'(table_ff[hit.idx]);
                     end else begin
                        rsp_data_in = req_tdata;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL: begin
            walk_in = walk_ff + LETTER_W'(1);
            if (walk_ff == LETTER_W'(LETTER_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_ff      <= '0;
         used_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         used_ff      <= used_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // table comes out of reset as the identity mapping
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LETTER_COUNT; i++) begin
            table_ff[i] <= LETTER_W'(i);
         end
      end else if (ap_write) begin
         table_ff[fill_ff] <= ap_idx;
      end
   end

   // every used letter has exactly one table slot
   a_fill_matches_mask: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(fill_ff))
      else $error("fill count out of step with used mask");

   a_fill_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> !req_tready)
      else $error("input taken during finish walk");

   a_finish_complete: assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff) |-> (used_ff == '1 && fill_ff == LETTER_W'(LETTER_COUNT)))
      else $error("finish walk left letters unused");

   a_result_only_plain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || $past(rsp_tready)) && rsp_valid_ff |->
         $past(req_fire && req_tuser == KIND_PLAIN))
      else $error("result without plaintext transaction");

endmodule

// File: sim/keyword_substitution_cipher_core_tb.sv
// keyword_substitution_cipher_core_tb: self-checking bench for the keyword
// substitution cipher core; a scoreboard models the letter table and checks
// each ciphertext byte; depends on kwsc_pkg and keyword_substitution_cipher_core
`timescale 1ns / 1ps

module keyword_substitution_cipher_core_tb;

   import kwsc_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1300;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 40;

   // tracks the substitution table and the ciphertext bytes still owed
   class cipher_scoreboard;
      letter_type subst_table [LETTER_COUNT];
      mask_type   used_letters;
      int unsigned filled;
      byte_type   ciphertext_due [$];
      int unsigned mismatches;

      function new();
         for (int i = 0; i < LETTER_COUNT; i++) subst_table[i] = letter_type'(i);
         used_letters = '0;
         filled = 0;
         mismatches = 0;
      endfunction

      // alphabet position of a letter of either case, -1 otherwise
      function int alpha_pos(byte_type b);
         if (b >= 8'h41 && b <= 8'h5A) return int'(b) - 'h41;
         if (b >= 8'h61 && b <= 8'h7A) return int'(b) - 'h61;
         return -1;
      endfunction

      function void take_letter(int unsigned pos);
         if (used_letters[pos]) return;
         if (filled < LETTER_COUNT) begin
            subst_table[filled] = letter_type'(pos);
            filled++;
         end
         used_letters[pos] = 1'b1;
      endfunction

      function void note_transaction(kind_type kind, byte_type b);
         int pos;
         pos = alpha_pos(b);
         case (kind)
            KIND_CLEAR: begin
               used_letters = '0;
               filled = 0;
            end
            KIND_KEY: begin
               if (pos >= 0) take_letter(pos);
            end
            KIND_FINISH: begin
               for (int i = 0; i < LETTER_COUNT; i++) take_letter(i);
            end
            default: begin
               if (pos >= 0)
                  ciphertext_due.push_back(BASE_UPPER + byte_type'(subst_table[pos]));
               else
                  ciphertext_due.push_back(b);
            end
         endcase
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
      endfunction

      function void check_ciphertext(byte_type got);
         byte_type want;
         if (ciphertext_due.size() == 0) begin
            report($sformatf("unexpected out_byte 0x%02h", got));
            return;
         end
         want = ciphertext_due.pop_front();
         if (got !== want)
            report($sformatf("out_byte expected 0x%02h actual 0x%02h", want, got));
      endfunction

      function int unsigned pending();
         return ciphertext_due.size();
      endfunction
   endclass

   logic     clock      = 1'b0;
   logic     reset      = 1'b1;
   logic     req_tvalid = 1'b0;
   logic     req_tready;
   byte_type req_tdata  = '0;      // [7:0] in_byte
   kind_type req_tuser  = KIND_CLEAR; // [1:0] kind
   logic     rsp_tvalid;
   logic     rsp_tready = 1'b0;
   byte_type rsp_tdata;            // [7:0] out_byte

   cipher_scoreboard sb = new();

   int unsigned burst_left  = 0;
   bit          quiet_burst = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned stall_mode  = 0;
   int unsigned idle_cycles = 0;
   int unsigned items_sent  = 0;

   keyword_substitution_cipher_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // receiver back-pressure in one of four patterns, picked anew at random
   always @(negedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 128 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (cycle_count[1:0] == 2'd0);
         default: rsp_tready <= (cycle_count[2:0] >= 3'd5);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_ciphertext(rsp_tdata);
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL keyword_substitution_cipher_core");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input kind_type kind, input byte_type b);
      int unsigned gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         quiet_burst = ($urandom_range(0, 5) == 0);
         gap = quiet_burst ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_transaction(kind, b);
      if (!(kind == KIND_KEY && sb.alpha_pos(b) < 0)) items_sent++;
      @(negedge clock);
   endtask

   function automatic byte_type random_letter();
      byte_type b;
      b = 8'h41 + byte_type'($urandom_range(0, 25));
      if ($urandom_range(0, 1)) b = b | 8'h20;
      return b;
   endfunction

   function automatic byte_type random_byte();
      return byte_type'($urandom_range(0, 255));
   endfunction

   // clear, keyword, usually a finish, then a run of plaintext; sometimes raw noise
   task automatic send_message();
      int unsigned n;
      if ($urandom_range(0, 99) < 15) begin
         n = $urandom_range(1, 8);
         repeat (n) send_item(kind_type'($urandom_range(0, 3)), random_byte());
         return;
      end
      send_item(KIND_CLEAR, random_byte());
      n = $urandom_range(0, 12);
      repeat (n) begin
         if ($urandom_range(0, 7) == 0) send_item(KIND_KEY, random_byte());
         else send_item(KIND_KEY, random_letter());
      end
      // skipping the finish leaves a half-built table for lookups
      if ($urandom_range(0, 5) != 0) send_item(KIND_FINISH, random_byte());
      n = $urandom_range(1, 30);
      repeat (n) begin
         if ($urandom_range(0, 9) < 7) send_item(KIND_PLAIN, random_letter());
         else send_item(KIND_PLAIN, random_byte());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // identity table after reset and the letter range boundaries
      send_item(KIND_PLAIN, 8'h41);
      send_item(KIND_PLAIN, 8'h7A);
      send_item(KIND_PLAIN, 8'h00);
      send_item(KIND_PLAIN, 8'hFF);
      send_item(KIND_PLAIN, 8'h40);
      send_item(KIND_PLAIN, 8'h5B);
      send_item(KIND_PLAIN, 8'h60);
      send_item(KIND_PLAIN, 8'h7B);
      send_item(KIND_PLAIN, 8'h80);
      // lower-case keyword, repeat, non-letters
      send_item(KIND_KEY, 8'h7A);
      send_item(KIND_KEY, 8'h5A);
      send_item(KIND_KEY, 8'h31);
      send_item(KIND_KEY, 8'h71);
      send_item(KIND_KEY, 8'hC1);
      // lookups into a partly built table
      send_item(KIND_PLAIN, 8'h61);
      send_item(KIND_PLAIN, 8'h63);
      send_item(KIND_FINISH, 8'h00);
      send_item(KIND_FINISH, 8'hFF);
      send_item(KIND_PLAIN, 8'h4D);
      send_item(KIND_PLAIN, 8'h62);
      // clear keeps the old table entries
      send_item(KIND_CLEAR, 8'hAA);
      send_item(KIND_KEY, 8'h45);
      send_item(KIND_PLAIN, 8'h62);
      send_item(KIND_FINISH, 8'h55);
      send_item(KIND_PLAIN, 8'h59);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) send_message();
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS keyword_substitution_cipher_core");
      end else begin
         $display("FAIL keyword_substitution_cipher_core");
      end
      $finish;
   end

endmodule
